>>> rtl/rcpwm_pkg.sv
// ----------------------------------------------------------------------------
// RC PWM decoder package
// Shared constants, types and the pulse-width mapping function.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

    localparam int CNT_W   = 17;
    localparam int CMD_W   = 11;
    localparam int ACT_W   = 8;
    localparam int TICKS_W = 16;
    localparam int MAXP_W  = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TIMEOUT_EN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT_TICK = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_PULSE    = 2'd2;

    localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RST = 16'd16000;
    localparam logic [MAXP_W-1:0]  MAX_PULSE_RST     = 8'd64;

    localparam logic [14:0]        TICK_SCALE    = 15'd75;
    localparam logic signed [15:0] CENTER_OFFSET = 16'sd3600;
    localparam logic signed [15:0] CMD_LIMIT     = 16'sd1000;
    localparam logic signed [CMD_W-1:0] DEADBAND = 11'sd50;
    localparam logic [ACT_W-1:0]   ACTUATOR_ON   = 8'd250;

    typedef struct packed {
        logic accept;   // item taken this cycle
        logic lost;     // timeout fired: clear the counter
        logic zero;     // timeout with zeroing enabled: clear the command
    } t_chan_ctl;

    typedef struct packed {
        logic                    fall;       // valid pulse ended this item
        logic signed [CMD_W-1:0] cmd;        // command mapped from this pulse
        logic [CNT_W-1:0]        count_adv;  // counter after edge handling and advance
    } t_chan_sts;

    // width in ticks -> clamp(count*75 - 3600, -1000, 1000)
    function automatic logic signed [CMD_W-1:0] pulse_to_cmd(input logic [MAXP_W-1:0] count);
        logic [14:0]        prod;
        logic signed [15:0] v;
        prod = 15'(count) * TICK_SCALE;
        v    = $signed({1'b0, prod}) - CENTER_OFFSET;
        if (v > CMD_LIMIT) begin
            v = CMD_LIMIT;
        end else if (v < -CMD_LIMIT) begin
            v = -CMD_LIMIT;
        end
        return v[CMD_W-1:0];
    endfunction

endpackage

>>> rtl/rc_pwm_two_channel_decoder.sv
// ----------------------------------------------------------------------------
// RC PWM two-channel decoder
// Decodes speed and steer servo pulses sampled once per tick into signed
// commands, drives the actuator level, keep-alive and signal-loss flags.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------
//  input     | i_in_valid / o_in_ready  | i_speed_pin, i_steer_pin
//  result    | o_out_valid / i_out_ready| o_speed_cmd, o_steer_cmd,
//            |                          | o_actuator_cmd, o_keepalive_pulse,
//            |                          | o_signal_lost
//  config    | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
// One item per cycle while the result slot frees up: the result of a tick
// sample appears in the result register in the cycle after it is accepted.
// The throughput is set by the single pass from the channel state through
// edge handling, the 17-bit counter compare and the small pulse multiply.
// A new item is taken whenever the result register is empty or being taken.
// Reset (synchronous, active low) clears counters, commands and the result
// register, and loads the configuration defaults.
//
module rc_pwm_two_channel_decoder
    import rcpwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_speed_pin,
    input  logic                    i_steer_pin,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [CMD_W-1:0] o_speed_cmd,
    output logic signed [CMD_W-1:0] o_steer_cmd,
    output logic [ACT_W-1:0]        o_actuator_cmd,
    output logic                    o_keepalive_pulse,
    output logic                    o_signal_lost,

    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    // configuration
    logic               r_timeout_en;
    logic [TICKS_W-1:0] r_timeout_ticks;
    logic [MAXP_W-1:0]  r_max_pulse;

    // result register control and flags
    logic             r_out_valid;
    logic             r_keepalive;
    logic             r_lost;
    logic [ACT_W-1:0] r_actuator;
    logic [ACT_W-1:0] n_actuator;

    logic      accept;
    logic      lost;
    t_chan_ctl chan_ctl;
    t_chan_sts speed_sts;
    t_chan_sts steer_sts;

    // take a new item whenever the result slot frees up this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // timeout looks at both counters after they advance
    assign lost = (speed_sts.count_adv > {1'b0, r_timeout_ticks})
               || (steer_sts.count_adv > {1'b0, r_timeout_ticks});

    always_comb begin
        chan_ctl.accept = accept;
        chan_ctl.lost   = lost;
        chan_ctl.zero   = lost && r_timeout_en;
    end

    rcpwm_channel u_speed (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pin       (i_speed_pin),
        .i_negate    (1'b0),
        .i_max_pulse (r_max_pulse),
        .i_ctl       (chan_ctl),
        .o_sts       (speed_sts),
        .o_value     (o_speed_cmd)
    );

    // steer uses the mirrored mapping
    rcpwm_channel u_steer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pin       (i_steer_pin),
        .i_negate    (1'b1),
        .i_max_pulse (r_max_pulse),
        .i_ctl       (chan_ctl),
        .o_sts       (steer_sts),
        .o_value     (o_steer_cmd)
    );

    // actuator follows each speed update, dropped with the commands on timeout
    always_comb begin
        if (chan_ctl.zero) begin
            n_actuator = '0;
        end else if (speed_sts.fall) begin
            n_actuator = (speed_sts.cmd > DEADBAND || speed_sts.cmd < -DEADBAND)
                       ? ACTUATOR_ON : '0;
        end else begin
            n_actuator = r_actuator;
        end
    end

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_en    <= 1'b1;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
            r_max_pulse     <= MAX_PULSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIMEOUT_EN:   r_timeout_en    <= i_cfg_data[0];
                REG_TIMEOUT_TICK: r_timeout_ticks <= i_cfg_data[TICKS_W-1:0];
                REG_MAX_PULSE:    r_max_pulse     <= i_cfg_data[MAXP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // result register: load on accept, hold while stalled, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_keepalive <= 1'b0;
            r_lost      <= 1'b0;
            r_actuator  <= '0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
            r_keepalive <= speed_sts.fall;
            r_lost      <= lost;
            r_actuator  <= n_actuator;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_keepalive_pulse = r_keepalive;
    assign o_signal_lost     = r_lost;
    assign o_actuator_cmd    = r_actuator;

endmodule

>>> rtl/rcpwm_channel.sv
// ----------------------------------------------------------------------------
// RC PWM channel
// Edge detection, tick counter and command register for one PWM pin.
// ----------------------------------------------------------------------------
module rcpwm_channel
    import rcpwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pin,
    input  logic                    i_negate,
    input  logic [MAXP_W-1:0]       i_max_pulse,
    input  t_chan_ctl               i_ctl,
    output t_chan_sts               o_sts,
    output logic signed [CMD_W-1:0] o_value
);

    logic                    r_last;
    logic [CNT_W-1:0]        r_count;
    logic signed [CMD_W-1:0] r_value;

    logic                    n_last;
    logic [CNT_W-1:0]        n_count;
    logic signed [CMD_W-1:0] n_value;

    logic                    fall;
    logic                    rise;
    logic signed [CMD_W-1:0] mapped;
    logic [CNT_W-1:0]        count_base;

    // edge handling and status; kept apart from the next-state block so the
    // timeout path through the top level is not a loop
    always_comb begin
        fall       = !i_pin && r_last && (r_count <= {{(CNT_W-MAXP_W){1'b0}}, i_max_pulse});
        rise       = i_pin && !r_last;
        mapped     = pulse_to_cmd(r_count[MAXP_W-1:0]);
        // a locked channel (too-long pulse) keeps its last level high
        n_last     = fall ? 1'b0 : (rise ? 1'b1 : r_last);
        count_base = (fall || rise) ? '0 : r_count;

        o_sts.fall      = fall;
        o_sts.cmd       = i_negate ? CMD_W'(-mapped) : mapped;
        o_sts.count_adv = count_base + CNT_W'(1);
    end

    always_comb begin
        n_count = i_ctl.lost ? '0 : o_sts.count_adv;
        if (i_ctl.zero) begin
            n_value = '0;
        end else if (o_sts.fall) begin
            n_value = o_sts.cmd;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_count <= '0;
            r_value <= '0;
        end else if (i_ctl.accept) begin
            r_last  <= n_last;
            r_count <= n_count;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

>>> rtl/rcpwm_checker.sv
// ----------------------------------------------------------------------------
// RC PWM decoder checker
// Port-level assertions on the decoder, attached by bind.
// ----------------------------------------------------------------------------
module rcpwm_checker
    import rcpwm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [CMD_W-1:0] o_speed_cmd,
    input logic signed [CMD_W-1:0] o_steer_cmd,
    input logic [ACT_W-1:0]        o_actuator_cmd
);

    // actuator level always agrees with the speed deadband
    a_act_deadband: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_actuator_cmd == ACTUATOR_ON) == (o_speed_cmd > DEADBAND || o_speed_cmd < -DEADBAND))
        else $error("actuator level disagrees with speed command");

    // commands stay within the clamp range
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_speed_cmd >= -11'sd1000 && o_speed_cmd <= 11'sd1000
        && o_steer_cmd >= -11'sd1000 && o_steer_cmd <= 11'sd1000)
        else $error("command out of range");

    // an empty result slot never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_speed_cmd)
        && $stable(o_steer_cmd) && $stable(o_actuator_cmd))
        else $error("stalled result changed");

endmodule

bind rc_pwm_two_channel_decoder rcpwm_checker u_rcpwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_speed_cmd    (o_speed_cmd),
    .o_steer_cmd    (o_steer_cmd),
    .o_actuator_cmd (o_actuator_cmd)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM two-channel decoder testbench
// Streams sampled speed/steer pin levels into the decoder, predicts every
// tick result in a cycle-free software copy of the decoder and compares each
// returned result field by field, under random sender gaps, receiver stalls
// and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import rcpwm_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no handshake on either side
    localparam int SETTLE_CYCLES  = 4;      // result register is one stage deep

    // pulse-width to command mapping: width * 31.25 us, centered at 1500 us, gain 2.4
    localparam int PULSE_GAIN   = 75;
    localparam int PULSE_CENTER = 3600;
    localparam int CMD_CLAMP    = 1000;
    localparam int DEAD_ZONE    = 50;
    localparam logic [ACT_W-1:0] BLADE_ON = 8'd250;

    // index that maps to no register: writes must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [CMD_W-1:0] speed_cmd;
        logic signed [CMD_W-1:0] steer_cmd;
        logic [ACT_W-1:0]        actuator_cmd;
        logic                    keepalive;
        logic                    lost;
    } t_tick_result;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    speed_pin = 1'b0;
    logic                    steer_pin = 1'b0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [CMD_W-1:0] speed_cmd;
    logic signed [CMD_W-1:0] steer_cmd;
    logic [ACT_W-1:0]        actuator_cmd;
    logic                    keepalive_pulse;
    logic                    signal_lost;

    logic                    cfg_we = 1'b0;
    logic [IDX_W-1:0]        cfg_idx = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    always #1 clk = ~clk;

    rc_pwm_two_channel_decoder u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_speed_pin       (speed_pin),
        .i_steer_pin       (steer_pin),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_speed_cmd       (speed_cmd),
        .o_steer_cmd       (steer_cmd),
        .o_actuator_cmd    (actuator_cmd),
        .o_keepalive_pulse (keepalive_pulse),
        .o_signal_lost     (signal_lost),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Decoder copy: registers and per-channel state, reset values
    // ------------------------------------------------------------------------
    logic                    zero_on_loss = 1'b1;
    logic [TICKS_W-1:0]      loss_ticks   = TIMEOUT_TICKS_RST;
    logic [MAXP_W-1:0]       max_width    = MAX_PULSE_RST;

    logic                    speed_high  = 1'b0;
    logic                    steer_high  = 1'b0;
    logic [CNT_W-1:0]        speed_ticks = '0;
    logic [CNT_W-1:0]        steer_ticks = '0;
    logic signed [CMD_W-1:0] speed_now   = '0;
    logic signed [CMD_W-1:0] steer_now   = '0;
    logic [ACT_W-1:0]        blade_now   = '0;

    logic [1:0]   pin_q [$];          // pending items: bit 1 speed, bit 0 steer
    t_tick_result tick_results_q [$]; // results owed by the block, oldest first

    int n_sent      = 0;
    int n_taken     = 0;
    int n_errors    = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int stall_hold  = 0;
    logic [7:0] stall_mask = 8'hFF;

    // Map a pulse width in ticks to a clamped command.
    function automatic logic signed [CMD_W-1:0] width_to_cmd(input logic [CNT_W-1:0] width);
        int v;
        v = int'(width) * PULSE_GAIN - PULSE_CENTER;
        if (v > CMD_CLAMP) begin
            v = CMD_CLAMP;
        end else if (v < -CMD_CLAMP) begin
            v = -CMD_CLAMP;
        end
        return CMD_W'(v);
    endfunction

    // Advance the decoder copy by one sample tick and return what it outputs.
    // Falling edges first, then rising edges, then counter advance, then the
    // loss check.
    function automatic t_tick_result decode_tick(input logic sp, input logic st);
        t_tick_result r;
        r.keepalive = 1'b0;
        r.lost      = 1'b0;

        // A falling edge only counts when the pulse was short enough; a long
        // pulse leaves the channel looking high until a loss clears the counters.
        if (!sp && speed_high && speed_ticks <= max_width) begin
            speed_high  = 1'b0;
            speed_now   = width_to_cmd(speed_ticks);
            blade_now   = (speed_now > DEAD_ZONE || speed_now < -DEAD_ZONE) ? BLADE_ON : '0;
            r.keepalive = 1'b1;
            speed_ticks = '0;
        end
        if (!st && steer_high && steer_ticks <= max_width) begin
            steer_high  = 1'b0;
            steer_now   = -width_to_cmd(steer_ticks);
            steer_ticks = '0;
        end
        if (sp && !speed_high) begin
            speed_high  = 1'b1;
            speed_ticks = '0;
        end
        if (st && !steer_high) begin
            steer_high  = 1'b1;
            steer_ticks = '0;
        end

        speed_ticks = speed_ticks + 1'b1;
        steer_ticks = steer_ticks + 1'b1;

        // Loss fires regardless of the enable; only the zeroing is gated.
        if (speed_ticks > loss_ticks || steer_ticks > loss_ticks) begin
            r.lost = 1'b1;
            if (zero_on_loss) begin
                speed_now = '0;
                steer_now = '0;
                blade_now = '0;
            end
            speed_ticks = '0;
            steer_ticks = '0;
        end

        r.speed_cmd    = speed_now;
        r.steer_cmd    = steer_now;
        r.actuator_cmd = blade_now;
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [15:0] want_v,
                               input logic signed [15:0] got_v);
        if (got_v !== want_v) begin
            n_errors++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check results first, then record the item accepted at this edge
    // and push its predicted result. Both handshakes are sampled before the
    // block's registers update.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_tick_result want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (tick_results_q.size() == 0) begin
                    n_errors++;
                    $error("result returned with no item outstanding");
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("speed_cmd", want.speed_cmd, speed_cmd);
                    check_field("steer_cmd", want.steer_cmd, steer_cmd);
                    check_field("actuator_cmd", want.actuator_cmd, actuator_cmd);
                    check_field("keepalive_pulse", want.keepalive, keepalive_pulse);
                    check_field("signal_lost", want.lost, signal_lost);
                end
            end
            if (in_valid && in_ready) begin
                tick_results_q.push_back(decode_tick(speed_pin, steer_pin));
                n_taken++;
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: hold the current item until taken, then either idle for the
    // rest of a gap or present the next item. Bursts of random length are
    // separated by random gaps; some bursts run back to back with no gap.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : driver
        logic [1:0] pins;
        if (rst_n && n_sent == n_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pin_q.size() > 0) begin
                pins = pin_q.pop_front();
                speed_pin <= pins[1];
                steer_pin <= pins[0];
                in_valid  <= 1'b1;
                n_sent++;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: rotate a stall mask, pick a new one when its hold count runs out.
    // A third of the masks never stall; the others keep at least one ready bit.
    always @(negedge clk) begin : receiver
        if (stall_hold == 0) begin
            stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            stall_hold = $urandom_range(20, 80);
        end
        stall_hold--;
        stall_mask = {stall_mask[0], stall_mask[7:1]};
        out_ready <= stall_mask[0];
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Hold the sender until every item is taken and every result has returned.
    task automatic wait_idle();
        while (pin_q.size() != 0 || n_sent != n_taken || tick_results_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    // Write one register; only called with the block idle.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_TIMEOUT_EN:   zero_on_loss = data[0];
            REG_TIMEOUT_TICK: loss_ticks   = data[TICKS_W-1:0];
            REG_MAX_PULSE:    max_width    = data[MAXP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic en, input logic [TICKS_W-1:0] ticks,
                              input logic [MAXP_W-1:0] maxp);
        write_reg(REG_TIMEOUT_EN, CFG_W'(en));
        write_reg(REG_TIMEOUT_TICK, CFG_W'(ticks));
        write_reg(REG_MAX_PULSE, CFG_W'(maxp));
    endtask

    // Queue well-formed servo pulse trains on both pins with random content.
    // long_pct: share of pulses at or past the width limit (lock-up case once past it).
    // quiet_pct: share of low stretches long enough to declare signal loss.
    // About one tick in fifty carries a glitch on one or both pins.
    task automatic queue_pwm(input int n_ticks, input int long_pct, input int quiet_pct);
        logic       lvl [2];
        int         left [2];
        logic [1:0] pins;
        int         r;
        int         top;
        lvl  = '{1'b0, 1'b0};
        left = '{$urandom_range(1, 8), $urandom_range(1, 8)};
        top  = (max_width > 0) ? int'(max_width) : 1;
        for (int t = 0; t < n_ticks; t++) begin
            for (int c = 0; c < 2; c++) begin
                if (left[c] == 0) begin
                    lvl[c] = !lvl[c];
                    r = $urandom_range(0, 99);
                    if (lvl[c]) begin
                        if (r < long_pct) begin
                            left[c] = int'(max_width) + $urandom_range(0, 20);
                        end else if (r < long_pct + 10) begin
                            left[c] = $urandom_range(1, 8);
                        end else if (r < long_pct + 25) begin
                            left[c] = $urandom_range(1, top);
                        end else begin
                            left[c] = $urandom_range(30, 66);
                        end
                    end else if (r < quiet_pct) begin
                        left[c] = int'(loss_ticks) + $urandom_range(1, 10);
                    end else begin
                        left[c] = $urandom_range(1, 12);
                    end
                end
                left[c]--;
                pins[c] = lvl[c];
            end
            if ($urandom_range(0, 49) == 0) begin
                pins ^= 2'($urandom_range(1, 3));
            end
            pin_q.push_back(pins);
        end
    endtask

    // Queue random pin levels, each pin drawing a new random level half the time.
    task automatic queue_noise(input int n_ticks);
        logic [1:0] pins;
        pins = '0;
        for (int t = 0; t < n_ticks; t++) begin
            for (int c = 0; c < 2; c++) begin
                if ($urandom_range(0, 1) == 0) begin
                    pins[c] = $urandom_range(0, 1);
                end
            end
            pin_q.push_back(pins);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        // one-tick pulses on both pins, then a speed fall on the same tick as
        // a steer rise
        logic [1:0] warm_seq [6] = '{2'b00, 2'b11, 2'b00, 2'b10, 2'b01, 2'b00};
        // accepted short pulse, too-long pulse on both pins, lows until the
        // loss fires, the stale falling edge after it, then a steer pulse
        logic [1:0] lock_seq [14] = '{2'b10, 2'b00, 2'b11, 2'b11, 2'b11, 2'b00, 2'b00,
                                      2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b00};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset register values first, then a tight limit and
        // timeout so lock-up and loss show within a few ticks.
        foreach (warm_seq[i]) pin_q.push_back(warm_seq[i]);
        wait_idle();
        set_config(1'b1, 16'd6, 8'd2);
        foreach (lock_seq[i]) pin_q.push_back(lock_seq[i]);
        wait_idle();

        // Nominal servo timing.
        set_config(1'b1, 16'd16000, 8'd64);
        queue_pwm(350, 3, 0);
        wait_idle();

        // Short timeout with frequent loss; the sender also pauses halfway
        // until every result is back.
        set_config(1'b1, 16'd200, 8'd70);
        queue_pwm(175, 8, 4);
        wait_idle();
        queue_pwm(175, 8, 4);
        wait_idle();

        // Loss without zeroing, widest pulse limit.
        set_config(1'b0, 16'd150, 8'd255);
        queue_pwm(250, 5, 4);
        wait_idle();

        // Smallest nonzero timeout and pulse limit.
        set_config(1'b1, 16'd1, 8'd1);
        queue_noise(80);
        wait_idle();

        // Zero timeout and zero limit; high data bits must be masked and the
        // spare index ignored.
        write_reg(REG_TIMEOUT_EN, 16'hFFFF);
        write_reg(REG_TIMEOUT_TICK, 16'h0000);
        write_reg(REG_MAX_PULSE, 16'hFF00);
        write_reg(REG_SPARE, 16'h1234);
        queue_noise(50);
        wait_idle();

        // Largest timeout and pulse limit, zeroing off via a masked write.
        write_reg(REG_TIMEOUT_EN, 16'h0002);
        write_reg(REG_TIMEOUT_TICK, 16'hFFFF);
        write_reg(REG_MAX_PULSE, 16'h00FF);
        queue_pwm(250, 3, 0);
        wait_idle();

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_errors == 0 && tick_results_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rcpwm_pkg.sv
rtl/rcpwm_channel.sv
rtl/rc_pwm_two_channel_decoder.sv
rtl/rcpwm_checker.sv
dv/tb_top.sv
